### src/fci_pkg.sv
// ----------------------------------------------------------------------------
// fci_pkg: shared types and constants for the fan curve interpolator
// Field widths, curve geometry, register indexes and pipeline records.
// ----------------------------------------------------------------------------
package fci_pkg;

  // Field widths
  localparam int TempW     = 8;
  localparam int DutyW     = 8;
  localparam int CountW    = 5;
  localparam int CfgDataW  = 64;
  localparam int CfgIdxW   = 3;

  // Curve geometry
  localparam int MaxCurvePoints = 16;
  localparam int PointIdxW      = $clog2(MaxCurvePoints);
  localparam int PointsPerWord  = 4;
  localparam int CurveWords     = MaxCurvePoints / PointsPerWord;
  localparam int PointW         = TempW + DutyW;

  localparam logic [CountW-1:0] MinPointCount   = CountW'(2);
  localparam logic [CountW-1:0] MaxPointCount   = CountW'(MaxCurvePoints);
  localparam logic [CountW-1:0] PointCountReset = CountW'(2);
  localparam logic [DutyW-1:0]  HottestDuty     = DutyW'(100);

  // Divider: quotient never exceeds the duty difference, so it fits DutyW bits
  localparam int DivSteps      = DutyW;
  localparam int StepsPerStage = 2;
  localparam int DivStages     = DivSteps / StepsPerStage;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_POINT_COUNT  = 3'd0,
    REG_CURVE_WORD_0 = 3'd1,
    REG_CURVE_WORD_1 = 3'd2,
    REG_CURVE_WORD_2 = 3'd3,
    REG_CURVE_WORD_3 = 3'd4
  } fci_reg_t;

  // Segment record after point selection
  typedef struct packed {
    logic             direct;   // result known without interpolation
    logic [DutyW-1:0] dduty;    // that result
    logic             neg;      // duty falls along the segment
    logic [DutyW-1:0] da;       // lower duty
    logic [DutyW-1:0] diff;     // duty difference magnitude
    logic [TempW-1:0] offset;   // temperature above the lower point
    logic [TempW-1:0] width;    // segment width
  } fci_seg_t;

  // Record carried through the divider stages
  typedef struct packed {
    logic             direct;
    logic [DutyW-1:0] dduty;
    logic             neg;
    logic [DutyW-1:0] da;
    logic [TempW-1:0] divisor;
    logic [TempW-1:0] rem;      // partial remainder, always below divisor
    logic [DutyW-1:0] nq;       // dividend bits still to go, then quotient bits
  } fci_div_t;

endpackage

### src/fci_in_if.sv
// ----------------------------------------------------------------------------
// fci_in_if: temperature sample channel
// Valid/ready channel carrying one temperature beat.
// ----------------------------------------------------------------------------
interface fci_in_if;
  logic                       valid;
  logic                       ready;
  logic [fci_pkg::TempW-1:0]  temperature;
  logic                       hottest_step;

  modport source (output valid, output temperature, output hottest_step, input ready);
  modport sink   (input valid, input temperature, input hottest_step, output ready);
endinterface

### src/fci_out_if.sv
// ----------------------------------------------------------------------------
// fci_out_if: fan duty channel
// Valid/ready channel carrying one duty beat.
// ----------------------------------------------------------------------------
interface fci_out_if;
  logic                       valid;
  logic                       ready;
  logic [fci_pkg::DutyW-1:0]  fan_duty;

  modport source (output valid, output fan_duty, input ready);
  modport sink   (input valid, input fan_duty, output ready);
endinterface

### src/fci_cfg_if.sv
// ----------------------------------------------------------------------------
// fci_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fci_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fci_pkg::CfgIdxW-1:0]   index;
  logic [fci_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/fan_curve_interpolator.sv
// ----------------------------------------------------------------------------
// fan_curve_interpolator: piecewise-linear fan curve lookup
// Maps a temperature to a fan duty through a configured curve of up to
// sixteen points, with a forced full-step duty.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one beat per sample (temperature, hottest_step).
//   out_chan : one fan_duty beat per input beat, in order.
//   cfg_chan : register writes (point count, four curve words); always
//              ready. Write only while no sample is in flight.
// Stages: segment search, point fetch and offsets, multiply, four
//   divider stages of two quotient bits each, then the final add or
//   subtract into the output register.
// Throughput: one sample per cycle unless stalled; the whole pipeline advances together.
// Reset: pipeline emptied, point count 2, all curve words zero.
// Stall: when out_chan is not ready and the output register holds a beat,
//   every stage holds and in_chan.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fan_curve_interpolator (
  input  logic clk,
  input  logic rst_n,
  fci_in_if.sink    in_chan,
  fci_out_if.source out_chan,
  fci_cfg_if.sink   cfg_chan
);
  import fci_pkg::*;

  // Configuration registers
  logic [CountW-1:0]   point_count_r;
  logic [CfgDataW-1:0] curve_r [CurveWords];

  // Unpacked curve points
  logic [TempW-1:0] pt_temp [MaxCurvePoints];
  logic [DutyW-1:0] pt_duty [MaxCurvePoints];

  logic adv;

  // Stage 1: segment search
  logic                 v1_r;
  logic [TempW-1:0]     temp1_r;
  logic                 hot1_r;
  logic                 low1_r;
  logic                 found1_r;
  logic [PointIdxW-1:0] sel1_r;
  logic [PointIdxW-1:0] last1_r;
  logic                 low_nxt;
  logic                 found_nxt;
  logic [PointIdxW-1:0] sel_nxt;
  logic [PointIdxW-1:0] last_nxt;
  logic [CountW-1:0]    n_clamp;

  // Stage 2: segment record
  logic     v2_r;
  fci_seg_t seg2_r;
  fci_seg_t seg_nxt;

  // Stage 3: product, divider entry
  logic     v3_r;
  fci_div_t div3_r;
  fci_div_t div_nxt;

  // Divider chain
  logic     dv   [DivStages+1];
  fci_div_t drec [DivStages+1];

  // Output register
  logic             out_valid_r;
  logic [DutyW-1:0] out_duty_r;
  logic [DutyW-1:0] duty_nxt;

  // Write configuration registers; indexes beyond the list are dropped
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= PointCountReset;
      for (int w = 0; w < CurveWords; w++) begin
        curve_r[w] <= '0;
      end
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_POINT_COUNT:  point_count_r <= cfg_chan.data[CountW-1:0];
        REG_CURVE_WORD_0: curve_r[0]    <= cfg_chan.data;
        REG_CURVE_WORD_1: curve_r[1]    <= cfg_chan.data;
        REG_CURVE_WORD_2: curve_r[2]    <= cfg_chan.data;
        REG_CURVE_WORD_3: curve_r[3]    <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Unpack points: temperature low byte, duty high byte
  always_comb begin
    for (int w = 0; w < CurveWords; w++) begin
      for (int p = 0; p < PointsPerWord; p++) begin
        pt_temp[w*PointsPerWord + p] = curve_r[w][p*PointW +: TempW];
        pt_duty[w*PointsPerWord + p] = curve_r[w][p*PointW + TempW +: DutyW];
      end
    end
  end

  // Whole pipeline moves when the output register is free or being drained
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // Clamp point count, find first point not below the temperature
  always_comb begin
    logic [CountW-1:0] n_m1;
    if (point_count_r < MinPointCount) begin
      n_clamp = MinPointCount;
    end else if (point_count_r > MaxPointCount) begin
      n_clamp = MaxPointCount;
    end else begin
      n_clamp = point_count_r;
    end
    n_m1      = n_clamp - CountW'(1);
    last_nxt  = n_m1[PointIdxW-1:0];
    low_nxt   = in_chan.temperature <= pt_temp[0];
    found_nxt = 1'b0;
    sel_nxt   = '0;
    for (int k = MaxCurvePoints - 1; k >= 1; k--) begin
      if ((CountW'(k) < n_clamp) && (in_chan.temperature <= pt_temp[k])) begin
        found_nxt = 1'b1;
        sel_nxt   = PointIdxW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      temp1_r  <= in_chan.temperature;
      hot1_r   <= in_chan.hottest_step;
      low1_r   <= low_nxt;
      found1_r <= found_nxt;
      sel1_r   <= sel_nxt;
      last1_r  <= last_nxt;
    end
  end

  // Fetch segment ends, form offset, width and duty difference
  always_comb begin
    logic [PointIdxW-1:0] lo_idx;
    logic [TempW-1:0]     ta;
    logic [TempW-1:0]     tb;
    logic [DutyW-1:0]     da;
    logic [DutyW-1:0]     db;
    lo_idx = sel1_r - PointIdxW'(1);
    ta     = pt_temp[lo_idx];
    tb     = pt_temp[sel1_r];
    da     = pt_duty[lo_idx];
    db     = pt_duty[sel1_r];

    seg_nxt.neg    = db < da;
    seg_nxt.da     = da;
    seg_nxt.diff   = (db < da) ? (da - db) : (db - da);
    seg_nxt.offset = temp1_r - ta;
    seg_nxt.width  = tb - ta;

    priority if (hot1_r) begin
      seg_nxt.direct = 1'b1;
      seg_nxt.dduty  = HottestDuty;
    end else if (low1_r) begin
      seg_nxt.direct = 1'b1;
      seg_nxt.dduty  = pt_duty[0];
    end else if (!found1_r) begin
      seg_nxt.direct = 1'b1;
      seg_nxt.dduty  = pt_duty[last1_r];
    end else begin
      seg_nxt.direct = 1'b0;
      seg_nxt.dduty  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg2_r <= seg_nxt;
    end
  end

  // Multiply difference by offset; high byte seeds the remainder
  always_comb begin
    logic [DutyW+TempW-1:0] prod;
    prod            = seg2_r.diff * seg2_r.offset;
    div_nxt.direct  = seg2_r.direct;
    div_nxt.dduty   = seg2_r.dduty;
    div_nxt.neg     = seg2_r.neg;
    div_nxt.da      = seg2_r.da;
    div_nxt.divisor = seg2_r.width;
    div_nxt.rem     = prod[DutyW+TempW-1:DutyW];
    div_nxt.nq      = prod[DutyW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div3_r <= div_nxt;
    end
  end

  // Divider stages
  assign dv[0]   = v3_r;
  assign drec[0] = div3_r;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    fci_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (dv[g]),
      .in_rec    (drec[g]),
      .out_valid (dv[g+1]),
      .out_rec   (drec[g+1])
    );
  end

  // Apply the quotient to the lower duty, or pass the direct result
  always_comb begin
    if (drec[DivStages].direct) begin
      duty_nxt = drec[DivStages].dduty;
    end else if (drec[DivStages].neg) begin
      duty_nxt = drec[DivStages].da - drec[DivStages].nq;
    end else begin
      duty_nxt = drec[DivStages].da + drec[DivStages].nq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv[DivStages];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_duty_r <= duty_nxt;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.fan_duty = out_duty_r;

endmodule

### src/fci_div_stage.sv
// ----------------------------------------------------------------------------
// fci_div_stage: one register stage of the restoring divider
// Runs StepsPerStage restoring steps on the carried record and registers it.
// ----------------------------------------------------------------------------
module fci_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  fci_pkg::fci_div_t in_rec,
  output logic              out_valid,
  output fci_pkg::fci_div_t out_rec
);
  import fci_pkg::*;

  logic     valid_r;
  fci_div_t rec_r;
  fci_div_t rec_nxt;

  // Shift one dividend bit into the remainder per step, subtract when it fits
  always_comb begin
    logic [TempW:0] trial;
    rec_nxt = in_rec;
    for (int s = 0; s < StepsPerStage; s++) begin
      trial = {rec_nxt.rem, rec_nxt.nq[DutyW-1]};
      if (trial >= {1'b0, rec_nxt.divisor}) begin
        rec_nxt.rem = TempW'(trial - {1'b0, rec_nxt.divisor});
        rec_nxt.nq  = {rec_nxt.nq[DutyW-2:0], 1'b1};
      end else begin
        rec_nxt.rem = trial[TempW-1:0];
        rec_nxt.nq  = {rec_nxt.nq[DutyW-2:0], 1'b0};
      end
    end
  end

  // Advance with the rest of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rec   = rec_r;

endmodule
